@@ hw/rtl/b2da_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// b2da_pkg
// Shared types and constants for the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package b2da_pkg;

    localparam int NUMBER_WIDTH       = 32;
    localparam int BIT_CNT_WIDTH      = $clog2(NUMBER_WIDTH);
    localparam int BCD_WIDTH          = 4;
    localparam int CHAR_WIDTH         = 6;
    localparam int OUT_TDATA_WIDTH    = 8;
    localparam int DEFAULT_MAX_DIGITS = 10;

    localparam logic [BCD_WIDTH-1:0]  DABBLE_LIMIT  = 4'd5;
    localparam logic [BCD_WIDTH-1:0]  DABBLE_ADJUST = 4'd3;
    localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO    = 6'd48;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_CLEAR  = 2'd1,
        CELL_DABBLE = 2'd2,
        CELL_SHIFT  = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
    } cell_ctrl_t;

endpackage : b2da_pkg
`default_nettype wire

@@ hw/rtl/b2da_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// b2da_cell
// One decimal digit of the conversion chain: a shift-and-add-three step
// during conversion, and a plain digit shift towards the top during output.
// ----------------------------------------------------------------------------
module b2da_cell
    import b2da_pkg::*;
(
    input  wire logic                 clk,
    input  wire cell_ctrl_t           ctrl,
    input  wire logic                 bit_in,
    input  wire logic [BCD_WIDTH-1:0] digit_in,
    output logic                      carry_out,
    output logic      [BCD_WIDTH-1:0] digit
);

    logic [BCD_WIDTH-1:0] digit_reg;
    logic [BCD_WIDTH-1:0] digit_next;
    logic [BCD_WIDTH-1:0] adjusted;

    always_comb
    begin
        if (digit_reg >= DABBLE_LIMIT)
        begin
            adjusted = digit_reg + DABBLE_ADJUST;
        end
        else
        begin
            adjusted = digit_reg;
        end

        case (ctrl.op)
            CELL_CLEAR:  digit_next = '0;
            CELL_DABBLE: digit_next = {adjusted[BCD_WIDTH-2:0], bit_in};
            CELL_SHIFT:  digit_next = digit_in;
            default:     digit_next = digit_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

    assign carry_out = adjusted[BCD_WIDTH-1];
    assign digit     = digit_reg;

endmodule : b2da_cell
`default_nettype wire

@@ hw/rtl/binary_to_decimal_ascii.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// Converts an unsigned 32-bit number into its decimal ASCII digits, most
// significant first, without leading zeros.
// ----------------------------------------------------------------------------
// Each accepted number is loaded, converted by shift-and-add-three over every
// input bit through a chain of MAX_DIGITS digit cells, and then the chain
// shifts towards the top cell, leading zeros being dropped and the remaining
// digits emitted one per cycle while the output side does not stall. Zero
// gives the single character '0', and only the low MAX_DIGITS digits are kept.
// The final character of each number carries tlast, and a new number is taken
// while that character still waits in the output register.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii
    import b2da_pkg::*;
#(
    parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [NUMBER_WIDTH-1:0]    s_tdata,   // [31:0] number
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic      [OUT_TDATA_WIDTH-1:0] m_tdata,   // [5:0] digit_char, [7:6] zero
    output logic                            m_tlast
);

    localparam int REMAIN_WIDTH = $clog2(MAX_DIGITS + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t                   state_reg,  state_next;
    logic [NUMBER_WIDTH-1:0]  num_reg,    num_next;
    logic [BIT_CNT_WIDTH-1:0] bit_cnt_reg, bit_cnt_next;
    logic [REMAIN_WIDTH-1:0]  remain_reg, remain_next;
    logic                     started_reg, started_next;
    logic                     out_valid_reg, out_valid_next;
    logic [CHAR_WIDTH-1:0]    out_char_reg, out_char_next;
    logic                     out_last_reg, out_last_next;

    cell_ctrl_t               cell_ctrl;
    logic [MAX_DIGITS-1:0]    carry;
    logic [BCD_WIDTH-1:0]     digit [MAX_DIGITS];
    logic [BCD_WIDTH-1:0]     top_digit;
    logic                     out_free;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_DIGITS; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_first
                b2da_cell u_cell (
                    .clk       (clk),
                    .ctrl      (cell_ctrl),
                    .bit_in    (num_reg[NUMBER_WIDTH-1]),
                    .digit_in  ({BCD_WIDTH{1'b0}}),
                    .carry_out (carry[gi]),
                    .digit     (digit[gi])
                );
            end
            else
            begin : g_next
                b2da_cell u_cell (
                    .clk       (clk),
                    .ctrl      (cell_ctrl),
                    .bit_in    (carry[gi-1]),
                    .digit_in  (digit[gi-1]),
                    .carry_out (carry[gi]),
                    .digit     (digit[gi])
                );
            end
        end
    endgenerate

    assign top_digit = digit[MAX_DIGITS-1];
    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        num_next       = num_reg;
        bit_cnt_next   = bit_cnt_reg;
        remain_next    = remain_reg;
        started_next   = started_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        cell_ctrl.op   = CELL_HOLD;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    num_next     = s_tdata;
                    bit_cnt_next = '0;
                    cell_ctrl.op = CELL_CLEAR;
                    state_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cell_ctrl.op = CELL_DABBLE;
                num_next     = {num_reg[NUMBER_WIDTH-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + BIT_CNT_WIDTH'(1);
                if (bit_cnt_reg == BIT_CNT_WIDTH'(NUMBER_WIDTH - 1))
                begin
                    remain_next  = REMAIN_WIDTH'(MAX_DIGITS);
                    started_next = 1'b0;
                    state_next   = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    cell_ctrl.op = CELL_SHIFT;
                    remain_next  = remain_reg - REMAIN_WIDTH'(1);
                    if ((top_digit != '0) || started_reg || (remain_reg == REMAIN_WIDTH'(1)))
                    begin
                        out_valid_next = 1'b1;
                        out_char_next  = ASCII_ZERO + {{(CHAR_WIDTH-BCD_WIDTH){1'b0}}, top_digit};
                        out_last_next  = (remain_reg == REMAIN_WIDTH'(1));
                        started_next   = 1'b1;
                    end
                    if (remain_reg == REMAIN_WIDTH'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bit_cnt_reg   <= '0;
            remain_reg    <= '0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bit_cnt_reg   <= bit_cnt_next;
            remain_reg    <= remain_next;
            started_reg   <= started_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg      <= num_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_WIDTH-CHAR_WIDTH){1'b0}}, out_char_reg};
    assign m_tlast  = out_last_reg;

endmodule : binary_to_decimal_ascii
`default_nettype wire
